// ===== src/nnzf_pkg.sv =====
// ============================================================================
// nnzf_pkg - shared types for the nearest-nonzero zero fill unit
// Cell width, configuration width, sequencer states and the control and
// result bundles passed between the top level and the distance tracker.
// ============================================================================
package nnzf_pkg;

    localparam int VALUE_W = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0]   SIZE_RESET = 4'd8;
    localparam logic [VALUE_W-1:0] CELL_ZERO  = '0;

    typedef enum logic [2:0]
    {
        ST_LOAD,
        ST_CHECK_RD,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed
    {
        logic clear;     // restart the search for a new hole
        logic cand_vld;  // candidate cell data valid this cycle
    } track_ctrl_t;

    typedef struct packed
    {
        logic                       fill_ok;    // single nearest nonzero found
        logic signed [VALUE_W-1:0]  fill_value; // its value
    } track_result_t;

endpackage

// ===== src/nnzf_best_tracker.sv =====
// ============================================================================
// nnzf_best_tracker - nearest nonzero candidate search
// Takes one candidate cell per cycle, keeps the least Manhattan distance,
// its value and a tie flag. The result reflects the candidate of this cycle.
// ============================================================================
module nnzf_best_tracker
#(
    parameter int CW     = 3,
    parameter int DIST_W = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nnzf_pkg::track_ctrl_t               ctrl,
    input  logic [CW-1:0]                       here_row,
    input  logic [CW-1:0]                       here_col,
    input  logic [CW-1:0]                       cand_row,
    input  logic [CW-1:0]                       cand_col,
    input  logic signed [nnzf_pkg::VALUE_W-1:0] cand_value,
    output nnzf_pkg::track_result_t             result
);
    import nnzf_pkg::*;

    localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

    logic [DIST_W-1:0]         best_dist_reg, best_dist_next;
    logic signed [VALUE_W-1:0] best_value_reg, best_value_next;
    logic                      tie_reg, tie_next;
    logic [CW-1:0]             row_diff, col_diff;
    logic [DIST_W-1:0]         cand_dist;

    assign row_diff = (here_row >= cand_row) ? (here_row - cand_row) : (cand_row - here_row);
    assign col_diff = (here_col >= cand_col) ? (here_col - cand_col) : (cand_col - here_col);
    assign cand_dist = DIST_W'(row_diff) + DIST_W'(col_diff);

    always_comb
    begin
        best_dist_next  = best_dist_reg;
        best_value_next = best_value_reg;
        tie_next        = tie_reg;
        if (ctrl.clear)
        begin
            best_dist_next  = DIST_NONE;
            best_value_next = '0;
            tie_next        = 1'b0;
        end
        else if (ctrl.cand_vld && (cand_value != CELL_ZERO))
        begin
            if (cand_dist < best_dist_reg)
            begin
                best_dist_next  = cand_dist;
                best_value_next = cand_value;
                tie_next        = 1'b0;
            end
            else if (cand_dist == best_dist_reg)
            begin
                tie_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg  <= DIST_NONE;
            best_value_reg <= '0;
            tie_reg        <= 1'b0;
        end
        else
        begin
            best_dist_reg  <= best_dist_next;
            best_value_reg <= best_value_next;
            tie_reg        <= tie_next;
        end
    end

    assign result.fill_ok    = (best_dist_next != DIST_NONE) && !tie_next;
    assign result.fill_value = best_value_next;

    // a tie needs an earlier find
    a_tie_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        tie_reg |-> (best_dist_reg != DIST_NONE))
        else $error("tie flagged with no candidate found");

    // a recorded best is always a nonzero cell
    a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (best_dist_reg != DIST_NONE) |-> (best_value_reg != CELL_ZERO))
        else $error("best value is zero");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> ((best_dist_reg == DIST_NONE) && !tie_reg))
        else $error("search not restarted after clear");

endmodule

// ===== src/nearest_nonzero_zero_fill_unit.sv =====
// ============================================================================
// nearest_nonzero_zero_fill_unit - in-place nearest nonzero fill of a matrix
// Loads an n-by-n matrix, fills each hole from its single nearest nonzero
// cell in a row-major pass, then streams the matrix out.
// ============================================================================
// Loading takes one item per cycle while in the load state; n comes from
// matrix_size (0 acts as 1, above MAX_SIDE acts as MAX_SIDE) as it stands
// when each item arrives. The item that completes n*n cells starts the
// fill, which runs on a single-port read / single-port write store with
// registered read data: a nonzero cell is read and checked; a zero cell is
// read and checked, then all n*n cells are read as candidates (one candidate
// read per cycle), then write-back. Output follows from the same read port
// with one read in flight at a time, the final item flagged on tlast.
// Input is taken again as soon as the last read is issued, while the final
// outputs still drain. matrix_size may only be written between matrices or
// mid-load, never during fill or output. No clearing pass after reset.
// ============================================================================
module nearest_nonzero_zero_fill_unit
#(
    parameter int MAX_SIDE = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: matrix_size [3:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnzf_pkg::CFG_W-1:0]          cfg_data,
    // s_tdata: cell_value [31:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [nnzf_pkg::VALUE_W-1:0] s_tdata,
    // m_tdata: filled_value [31:0]; m_tlast: last_cell
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [nnzf_pkg::VALUE_W-1:0] m_tdata,
    output logic                                m_tlast
);
    import nnzf_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int DIST_W = $clog2(2 * MAX_SIDE);

    // cell store, one read and one write port
    logic signed [VALUE_W-1:0] store_mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      rd_en, wr_en;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic signed [VALUE_W-1:0] wr_data;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  size_reg;
    logic [SIDE_W-1:0] side;
    logic [CNT_W-1:0]  total_in;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [CNT_W-1:0]  load_inc;
    logic              in_acc, load_done;

    // fill scan position: cell k at (r, c), candidate j at (p, q)
    logic [CNT_W-1:0]  total_reg, total_next, total_m1;
    logic [CW-1:0]     last_coord_reg, last_coord_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CW-1:0]     r_reg, r_next, c_reg, c_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CW-1:0]     p_reg, p_next, q_reg, q_next;
    logic              cell_last;

    // candidate coordinates aligned with read data
    logic              cand_vld_reg;
    logic [CW-1:0]     cand_p_reg, cand_q_reg;

    // output side
    logic [CNT_W-1:0]          e_reg, e_next;
    logic                      emit_issue;
    logic                      rd_pend_reg, rd_last_reg;
    logic                      out_vld_reg, out_last_reg;
    logic signed [VALUE_W-1:0] out_data_reg;

    track_ctrl_t   trk_ctrl;
    track_result_t trk_res;

    // ------------------------------------------------------------------
    // side and load bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        if (size_reg == '0)
            side = SIDE_W'(1);
        else if (32'(size_reg) > MAX_SIDE)
            side = SIDE_W'(MAX_SIDE);
        else
            side = SIDE_W'(size_reg);
    end

    assign total_in  = CNT_W'(side) * CNT_W'(side);
    assign in_acc    = s_tvalid && s_tready;
    assign load_inc  = load_count_reg + CNT_W'(1);
    assign load_done = in_acc && (load_inc >= total_in);

    assign total_m1  = total_reg - CNT_W'(1);
    assign cell_last = (k_reg == total_m1);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);

    // one output item in flight: read only when the output register is
    // free next cycle
    assign emit_issue = (state_reg == ST_EMIT) && !rd_pend_reg && (!out_vld_reg || m_tready);

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_done)
                    state_next = ST_CHECK_RD;
            end
            ST_CHECK_RD:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (rd_data_reg != CELL_ZERO)
                    state_next = cell_last ? ST_EMIT : ST_CHECK_RD;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (j_reg == total_m1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = cell_last ? ST_EMIT : ST_CHECK_RD;
            ST_EMIT:
            begin
                if (emit_issue && (e_reg == total_m1))
                    state_next = ST_LOAD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: store port and tracker control
    // ------------------------------------------------------------------
    always_comb
    begin
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = s_tdata;
        trk_ctrl.clear    = 1'b0;
        trk_ctrl.cand_vld = cand_vld_reg;
        case (state_reg)
            ST_LOAD:
            begin
                wr_en   = in_acc;
                wr_addr = load_count_reg[AW-1:0];
                wr_data = s_tdata;
            end
            ST_CHECK_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = k_reg[AW-1:0];
            end
            ST_CHECK:
                trk_ctrl.clear = 1'b1;
            ST_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg[AW-1:0];
            end
            ST_DRAIN:
            begin
                // last candidate lands this cycle; write back in place
                wr_en   = trk_res.fill_ok;
                wr_addr = k_reg[AW-1:0];
                wr_data = trk_res.fill_value;
            end
            ST_EMIT:
            begin
                rd_en   = emit_issue;
                rd_addr = e_reg[AW-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // counters
    // ------------------------------------------------------------------
    always_comb
    begin
        load_count_next = load_count_reg;
        total_next      = total_reg;
        last_coord_next = last_coord_reg;
        k_next          = k_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        j_next          = j_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        e_next          = e_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                    load_count_next = load_done ? '0 : load_inc;
                if (load_done)
                begin
                    total_next      = total_in;
                    last_coord_next = CW'(side - SIDE_W'(1));
                    k_next          = '0;
                    r_next          = '0;
                    c_next          = '0;
                end
            end
            ST_CHECK, ST_DRAIN:
            begin
                if ((state_reg == ST_CHECK) && (rd_data_reg == CELL_ZERO))
                begin
                    j_next = '0;
                    p_next = '0;
                    q_next = '0;
                end
                else
                begin
                    // next cell in row-major order
                    k_next = k_reg + CNT_W'(1);
                    if (c_reg == last_coord_reg)
                    begin
                        c_next = '0;
                        r_next = r_reg + CW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                    if (cell_last)
                        e_next = '0;
                end
            end
            ST_SCAN:
            begin
                j_next = j_reg + CNT_W'(1);
                if (q_reg == last_coord_reg)
                begin
                    q_next = '0;
                    p_next = p_reg + CW'(1);
                end
                else
                begin
                    q_next = q_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_issue)
                    e_next = e_reg + CNT_W'(1);
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            size_reg       <= SIZE_RESET;
            load_count_reg <= '0;
            cand_vld_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            cand_vld_reg   <= (state_reg == ST_SCAN);
            rd_pend_reg    <= emit_issue;
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            if (rd_pend_reg)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg      <= total_next;
        last_coord_reg <= last_coord_next;
        k_reg          <= k_next;
        r_reg          <= r_next;
        c_reg          <= c_next;
        j_reg          <= j_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        e_reg          <= e_next;
        cand_p_reg     <= p_reg;
        cand_q_reg     <= q_reg;
        rd_last_reg    <= emit_issue && (e_reg == total_m1);
        if (rd_pend_reg)
        begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // nearest candidate search
    // ------------------------------------------------------------------
    nnzf_best_tracker
    #(
        .CW     (CW),
        .DIST_W (DIST_W)
    )
    u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (trk_ctrl),
        .here_row   (r_reg),
        .here_col   (c_reg),
        .cand_row   (cand_p_reg),
        .cand_col   (cand_q_reg),
        .cand_value (rd_data_reg),
        .result     (trk_res)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // pending read data always finds the output register free
    a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (!out_vld_reg || m_tready) || !$past(out_vld_reg))
        else $error("output register overrun");

    // no write and read to the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("store read and write clash");

    // load count is cleared whenever a fill or output is under way
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (load_count_reg == '0))
        else $error("load count not cleared outside loading");

endmodule
